// File: hw/rtl/crc32sw_pkg.sv
// Shared types, codes and the CRC byte step for the skip-window CRC-32 block.
package crc32sw_pkg;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [63:0] OFFSET_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WIN_BASE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_LENGTH = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [63:0] byte_offset;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic        was_skipped;
        logic [31:0] crc_value;
        logic [63:0] skipped_total;
    } res_t;

    typedef enum logic [1:0] {
        OP_CRC,
        OP_SKIP,
        OP_REJECT,
        OP_IDLE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
    } work_t;

    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = {24'd0, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c ^ (crc >> 8);
    endfunction

endpackage

// File: hw/rtl/crc32sw_front.sv
// Front end: classify each request against the enable flag, the reserved last offset and the skip window.
module crc32sw_front (
    input  logic                 byte_valid,
    input  crc32sw_pkg::req_t    byte_req,
    input  logic                 enable,
    input  logic [63:0]          win_base,
    input  logic [63:0]          skip_length,
    output logic                 work_valid,
    output crc32sw_pkg::work_t   work
);

    logic [64:0] end_sum;
    logic [63:0] window_end;
    logic        in_window;

    assign end_sum    = {1'b0, win_base} + {1'b0, skip_length};
    assign window_end = end_sum[64] ? crc32sw_pkg::OFFSET_MAX : end_sum[63:0];
    assign in_window  = (byte_req.byte_offset >= win_base) &&
                        (byte_req.byte_offset < window_end);

    always_comb
    begin
        work_valid     = byte_valid;
        work.data_byte = byte_req.data_byte;
        if (!enable)
        begin
            work.op = crc32sw_pkg::OP_IDLE;
        end
        else if (byte_req.byte_offset == crc32sw_pkg::OFFSET_MAX)
        begin
            work.op = crc32sw_pkg::OP_REJECT;
        end
        else if (in_window)
        begin
            work.op = crc32sw_pkg::OP_SKIP;
        end
        else
        begin
            work.op = crc32sw_pkg::OP_CRC;
        end
    end

endmodule

// File: hw/rtl/crc32sw_queue.sv
// Short register queue between the front end and the back end.
module crc32sw_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    input  crc32sw_pkg::work_t   wr_data,
    output logic                 full,
    input  logic                 rd_ready,
    output logic                 rd_valid,
    output crc32sw_pkg::work_t   rd_data
);

    crc32sw_pkg::work_t                      entry_reg [crc32sw_pkg::QUEUE_DEPTH];
    logic [crc32sw_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [crc32sw_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [crc32sw_pkg::QUEUE_CNT_W-1:0]     count_reg, count_next;
    logic                                    push, pop;

    localparam logic [crc32sw_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        crc32sw_pkg::QUEUE_PTR_W'(crc32sw_pkg::QUEUE_DEPTH - 1);
    localparam logic [crc32sw_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
        crc32sw_pkg::QUEUE_CNT_W'(crc32sw_pkg::QUEUE_DEPTH);

    assign full     = (count_reg == FULL_COUNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && !full;
    assign pop      = rd_ready && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: hw/rtl/crc32sw_back.sv
// Back end: apply the classified byte to the CRC state and skip count, register the result.
module crc32sw_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 work_valid,
    input  crc32sw_pkg::work_t   work,
    output logic                 work_ready,
    output logic                 res_valid,
    input  logic                 res_stall,
    output crc32sw_pkg::res_t    res_data
);

    logic [31:0]         crc_state_reg, crc_state_next;
    logic [63:0]         skip_count_reg, skip_count_next;
    logic                res_valid_reg, res_valid_next;
    crc32sw_pkg::res_t   res_data_reg, res_data_next;
    logic                take;

    assign work_ready = !res_valid_reg || !res_stall;
    assign take       = work_valid && work_ready;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_data_reg;

    always_comb
    begin
        crc_state_next  = crc_state_reg;
        skip_count_next = skip_count_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_data_next   = res_data_reg;
        if (take)
        begin
            res_valid_next = 1'b1;
            res_data_next.accepted    = 1'b1;
            res_data_next.was_skipped = 1'b0;
            case (work.op)
                crc32sw_pkg::OP_CRC:
                begin
                    crc_state_next = crc32sw_pkg::crc_step(crc_state_reg, work.data_byte);
                end
                crc32sw_pkg::OP_SKIP:
                begin
                    skip_count_next           = skip_count_reg + 64'd1;
                    res_data_next.was_skipped = 1'b1;
                end
                crc32sw_pkg::OP_REJECT:
                begin
                    res_data_next.accepted = 1'b0;
                end
                default:
                begin
                end
            endcase
            res_data_next.crc_value = (work.op == crc32sw_pkg::OP_IDLE) ? 32'd0 :
                                      crc_state_next ^ crc32sw_pkg::CRC_ALL_ONES;
            res_data_next.skipped_total = skip_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_state_reg  <= crc32sw_pkg::CRC_ALL_ONES;
            skip_count_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            crc_state_reg  <= crc_state_next;
            skip_count_reg <= skip_count_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

endmodule

// File: hw/rtl/crc32_stream_with_skip_window.sv
// Top level of the streaming CRC-32 with one excluded offset window.
// Path: a request is held in the classification queue, then its result is registered in the back end.
// Throughput: one byte per cycle; byte_stall rises only when the two-entry
// classification queue is full, which happens when res_stall holds results back.
// Reset: CRC state all ones, skip count zero, enable on, empty window, no result pending.
module crc32_stream_with_skip_window (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [crc32sw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [crc32sw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                   byte_valid,
    output logic                                   byte_stall,
    input  crc32sw_pkg::req_t                      byte_req,
    output logic                                   res_valid,
    input  logic                                   res_stall,
    output crc32sw_pkg::res_t                      res_data
);

    logic                 enable_reg;
    logic [63:0]          win_base_reg;
    logic [63:0]          skip_length_reg;
    logic                 front_valid;
    crc32sw_pkg::work_t   front_work;
    logic                 queue_full;
    logic                 queue_valid;
    crc32sw_pkg::work_t   queue_work;
    logic                 back_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b1;
            win_base_reg    <= '0;
            skip_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                crc32sw_pkg::CFG_ENABLE:      enable_reg      <= cfg_data[0];
                crc32sw_pkg::CFG_WIN_BASE:    win_base_reg    <= cfg_data;
                crc32sw_pkg::CFG_SKIP_LENGTH: skip_length_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign byte_stall = queue_full;

    crc32sw_front u_front (
        .byte_valid  (byte_valid),
        .byte_req    (byte_req),
        .enable      (enable_reg),
        .win_base    (win_base_reg),
        .skip_length (skip_length_reg),
        .work_valid  (front_valid),
        .work        (front_work)
    );

    crc32sw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_data  (front_work),
        .full     (queue_full),
        .rd_ready (back_ready),
        .rd_valid (queue_valid),
        .rd_data  (queue_work)
    );

    crc32sw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (queue_valid),
        .work       (queue_work),
        .work_ready (back_ready),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

endmodule

// File: hw/rtl/crc32sw_checker.sv
// Port-level checks for the skip-window CRC-32 block, bound to the top level.
module crc32sw_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   byte_valid,
    input  logic                                   byte_stall,
    input  logic                                   res_valid,
    input  logic                                   res_stall,
    input  crc32sw_pkg::res_t                      res_data
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid && !byte_stall)
        else $error("result or stall present straight after reset");

    a_skip_implies_accept: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.was_skipped |-> res_data.accepted)
        else $error("skipped byte reported as rejected");

    a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(res_valid) && !$past(byte_valid) && !$past(res_valid, 2) &&
        !$past(byte_valid, 2) |-> !res_valid)
        else $error("result without a request");

endmodule

bind crc32_stream_with_skip_window crc32sw_checker u_crc32sw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
);
